// ===== rtl/ilex_pkg.sv =====
// ----------------------------------------------------------------------------
// ilex_pkg
// Shared types and character codes for the integer literal lexer.
// ----------------------------------------------------------------------------
package ilex_pkg;

  localparam int CHAR_W      = 8;
  localparam int VALUE_W     = 64;
  localparam int LEN_W       = 16;
  localparam int DIGIT_W     = 4;
  localparam int COUNT_BITS  = 16;

  localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2d;  // '-'
  localparam logic [CHAR_W-1:0] CH_UNDER = 8'h5f;  // '_'
  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;  // '0'
  localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;  // '9'
  localparam logic [CHAR_W-1:0] CH_ONE   = 8'h31;  // '1'
  localparam logic [CHAR_W-1:0] CH_SEVEN = 8'h37;  // '7'
  localparam logic [CHAR_W-1:0] CH_LC_A  = 8'h61;  // 'a'
  localparam logic [CHAR_W-1:0] CH_LC_F  = 8'h66;  // 'f'
  localparam logic [CHAR_W-1:0] CH_LC_X  = 8'h78;  // 'x'
  localparam logic [CHAR_W-1:0] CH_LC_B  = 8'h62;  // 'b'
  localparam logic [CHAR_W-1:0] CH_LC_O  = 8'h6f;  // 'o'
  localparam logic [CHAR_W-1:0] CASE_BIT = 8'h20;
  localparam logic [DIGIT_W-1:0] HEX_LETTER_OFS = 4'd10;

  typedef enum logic [2:0] {
    PH_START  = 3'd0,
    PH_SIGNED = 3'd1,
    PH_ZERO   = 3'd2,
    PH_DEC    = 3'd3,
    PH_HEX    = 3'd4,
    PH_BIN    = 3'd5,
    PH_OCT    = 3'd6
  } phase_t;

  typedef struct packed {
    logic emit;
    logic part;
  } step_ctl_t;

endpackage

// ===== rtl/ilex_step.sv =====
// ----------------------------------------------------------------------------
// ilex_step
// Next-state logic for one character: prefix detection, digit decode and
// accumulator update, count saturation and result decision.
// ----------------------------------------------------------------------------
module ilex_step #(
  parameter int COUNT_BITS = ilex_pkg::COUNT_BITS
) (
  input  logic [ilex_pkg::CHAR_W-1:0]  text_char,
  input  logic                         end_of_text,
  input  ilex_pkg::phase_t             phase,
  input  logic [ilex_pkg::VALUE_W-1:0] acc,
  input  logic                         neg,
  input  logic [COUNT_BITS-1:0]        cnt,
  output ilex_pkg::phase_t             phase_nxt,
  output logic [ilex_pkg::VALUE_W-1:0] acc_nxt,
  output logic                         neg_nxt,
  output logic [COUNT_BITS-1:0]        cnt_nxt,
  output ilex_pkg::step_ctl_t          ctl,
  output logic [ilex_pkg::VALUE_W-1:0] res_acc,
  output logic                         res_neg,
  output logic [COUNT_BITS-1:0]        res_cnt
);

  logic [ilex_pkg::CHAR_W-1:0]  low_c;
  logic                         handled;
  ilex_pkg::phase_t             ph_upd;
  ilex_pkg::phase_t             num_ph;
  logic                         dig_ok;
  logic [ilex_pkg::DIGIT_W-1:0] dig;
  logic [ilex_pkg::VALUE_W-1:0] acc_mul;
  logic [ilex_pkg::VALUE_W-1:0] acc_upd;
  logic                         neg_upd;
  logic                         part;
  logic [COUNT_BITS-1:0]        cnt_upd;

  assign low_c = text_char | ilex_pkg::CASE_BIT;

  always_comb begin
    handled = 1'b0;
    ph_upd  = phase;
    neg_upd = neg;
    acc_upd = acc;
    part    = 1'b0;
    dig_ok  = 1'b0;
    dig     = '0;
    acc_mul = '0;
    num_ph  = ilex_pkg::PH_DEC;

    if (phase == ilex_pkg::PH_START && text_char == ilex_pkg::CH_MINUS) begin
      neg_upd = 1'b1;
      ph_upd  = ilex_pkg::PH_SIGNED;
      handled = 1'b1;
    end else if ((phase == ilex_pkg::PH_START || phase == ilex_pkg::PH_SIGNED) &&
                 text_char == ilex_pkg::CH_ZERO) begin
      ph_upd  = ilex_pkg::PH_ZERO;
      handled = 1'b1;
    end else if (phase == ilex_pkg::PH_ZERO && !end_of_text &&
                 (text_char == ilex_pkg::CH_LC_X || text_char == ilex_pkg::CH_LC_B ||
                  text_char == ilex_pkg::CH_LC_O)) begin
      if (text_char == ilex_pkg::CH_LC_X) begin
        ph_upd = ilex_pkg::PH_HEX;
      end else if (text_char == ilex_pkg::CH_LC_B) begin
        ph_upd = ilex_pkg::PH_BIN;
      end else begin
        ph_upd = ilex_pkg::PH_OCT;
      end
      handled = 1'b1;
    end

    if (!handled) begin
      case (phase)
        ilex_pkg::PH_HEX, ilex_pkg::PH_BIN, ilex_pkg::PH_OCT: num_ph = phase;
        default:                                              num_ph = ilex_pkg::PH_DEC;
      endcase
      ph_upd = num_ph;

      case (num_ph)
        ilex_pkg::PH_HEX: begin
          if (text_char >= ilex_pkg::CH_ZERO && text_char <= ilex_pkg::CH_NINE) begin
            dig_ok = 1'b1;
            dig    = ilex_pkg::DIGIT_W'(text_char - ilex_pkg::CH_ZERO);
          end else if (low_c >= ilex_pkg::CH_LC_A && low_c <= ilex_pkg::CH_LC_F) begin
            dig_ok = 1'b1;
            dig    = ilex_pkg::DIGIT_W'(low_c - ilex_pkg::CH_LC_A) +
                     ilex_pkg::HEX_LETTER_OFS;
          end
          acc_mul = acc << 4;
        end
        ilex_pkg::PH_BIN: begin
          dig_ok  = (text_char >= ilex_pkg::CH_ZERO && text_char <= ilex_pkg::CH_ONE);
          dig     = ilex_pkg::DIGIT_W'(text_char - ilex_pkg::CH_ZERO);
          acc_mul = acc << 1;
        end
        ilex_pkg::PH_OCT: begin
          dig_ok  = (text_char >= ilex_pkg::CH_ZERO && text_char <= ilex_pkg::CH_SEVEN);
          dig     = ilex_pkg::DIGIT_W'(text_char - ilex_pkg::CH_ZERO);
          acc_mul = acc << 3;
        end
        default: begin
          dig_ok  = (text_char >= ilex_pkg::CH_ZERO && text_char <= ilex_pkg::CH_NINE);
          dig     = ilex_pkg::DIGIT_W'(text_char - ilex_pkg::CH_ZERO);
          acc_mul = (acc << 3) + (acc << 1);
        end
      endcase

      if (text_char == ilex_pkg::CH_UNDER) begin
        part = 1'b1;
      end else if (dig_ok) begin
        part    = 1'b1;
        acc_upd = acc_mul + ilex_pkg::VALUE_W'(dig);
      end
    end else begin
      part = 1'b1;
    end
  end

  assign cnt_upd = (part && cnt != {COUNT_BITS{1'b1}}) ? cnt + COUNT_BITS'(1) : cnt;

  assign ctl.part = part;
  assign ctl.emit = !part || end_of_text;

  assign res_acc = acc_upd;
  assign res_neg = neg_upd;
  assign res_cnt = cnt_upd;

  assign phase_nxt = ctl.emit ? ilex_pkg::PH_START : ph_upd;
  assign acc_nxt   = ctl.emit ? '0 : acc_upd;
  assign neg_nxt   = ctl.emit ? 1'b0 : neg_upd;
  assign cnt_nxt   = ctl.emit ? '0 : cnt_upd;

endmodule

// ===== rtl/integer_literal_lexer.sv =====
// ----------------------------------------------------------------------------
// integer_literal_lexer
// Streaming lexer for signed hex/binary/octal/decimal integer literals.
//
//   channel | dir | ports                                         | beat
//   in      | in  | in_text_char, in_end_of_text                  | one char
//   out     | out | out_literal_value, out_consumed_length,       | one result
//           |     | out_char_was_part                             |
//
// One character per cycle while in_stall is low; the character that ends the
// literal passes the input register, then the result register, to the output.
// Lexer state updates in a single step from the input register; the 64-bit
// multiply-by-base add is the critical path.
// Reset (rst_n low, synchronous) clears both valid flags and the lexer state.
// A stalled result holds; one further beat is buffered in the input register.
// ----------------------------------------------------------------------------
module integer_literal_lexer #(
  parameter int COUNT_BITS = ilex_pkg::COUNT_BITS
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [ilex_pkg::CHAR_W-1:0]  in_text_char,
  input  logic                         in_end_of_text,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [ilex_pkg::VALUE_W-1:0] out_literal_value,
  output logic [ilex_pkg::LEN_W-1:0]   out_consumed_length,
  output logic                         out_char_was_part
);

  logic                         s1_v_r;
  logic [ilex_pkg::CHAR_W-1:0]  s1_char_r;
  logic                         s1_eot_r;

  ilex_pkg::phase_t             phase_r;
  ilex_pkg::phase_t             phase_nxt;
  logic [ilex_pkg::VALUE_W-1:0] acc_r;
  logic [ilex_pkg::VALUE_W-1:0] acc_nxt;
  logic                         neg_r;
  logic                         neg_nxt;
  logic [COUNT_BITS-1:0]        cnt_r;
  logic [COUNT_BITS-1:0]        cnt_nxt;

  ilex_pkg::step_ctl_t          ctl;
  logic [ilex_pkg::VALUE_W-1:0] res_acc;
  logic                         res_neg;
  logic [COUNT_BITS-1:0]        res_cnt;

  logic                         out_v_r;
  logic [ilex_pkg::VALUE_W-1:0] out_acc_r;
  logic                         out_neg_r;
  logic [COUNT_BITS-1:0]        out_cnt_r;
  logic                         out_part_r;

  logic                         out_free;
  logic                         consume;
  logic                         in_acc;

  ilex_step #(
    .COUNT_BITS (COUNT_BITS)
  ) u_step (
    .text_char   (s1_char_r),
    .end_of_text (s1_eot_r),
    .phase       (phase_r),
    .acc         (acc_r),
    .neg         (neg_r),
    .cnt         (cnt_r),
    .phase_nxt   (phase_nxt),
    .acc_nxt     (acc_nxt),
    .neg_nxt     (neg_nxt),
    .cnt_nxt     (cnt_nxt),
    .ctl         (ctl),
    .res_acc     (res_acc),
    .res_neg     (res_neg),
    .res_cnt     (res_cnt)
  );

  assign out_free = !out_v_r || !out_stall;
  assign consume  = s1_v_r && (out_free || !ctl.emit);
  assign in_stall = s1_v_r && !consume;
  assign in_acc   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (in_acc) begin
      s1_v_r <= 1'b1;
    end else if (consume) begin
      s1_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_char_r <= in_text_char;
      s1_eot_r  <= in_end_of_text;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= ilex_pkg::PH_START;
      acc_r   <= '0;
      neg_r   <= 1'b0;
      cnt_r   <= '0;
    end else if (consume) begin
      phase_r <= phase_nxt;
      acc_r   <= acc_nxt;
      neg_r   <= neg_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (consume && ctl.emit) begin
      out_v_r <= 1'b1;
    end else if (!out_stall) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (consume && ctl.emit) begin
      out_acc_r  <= res_acc;
      out_neg_r  <= res_neg;
      out_cnt_r  <= res_cnt;
      out_part_r <= ctl.part;
    end
  end

  // sign applied after the result register
  assign out_valid         = out_v_r;
  assign out_literal_value = out_neg_r ? ilex_pkg::VALUE_W'(0) - out_acc_r : out_acc_r;
  assign out_char_was_part = out_part_r;

  generate
    if (COUNT_BITS >= ilex_pkg::LEN_W) begin : g_len_trunc
      assign out_consumed_length = out_cnt_r[ilex_pkg::LEN_W-1:0];
    end else begin : g_len_ext
      assign out_consumed_length = {{(ilex_pkg::LEN_W-COUNT_BITS){1'b0}}, out_cnt_r};
    end
  endgenerate

  a_start_clean: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == ilex_pkg::PH_START |-> (acc_r == '0 && !neg_r && cnt_r == '0))
    else $error("start phase with stale lexer state");

  a_signed_only_minus: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == ilex_pkg::PH_SIGNED |->
      (neg_r && acc_r == '0 && cnt_r == COUNT_BITS'(1)))
    else $error("signed phase inconsistent with one minus consumed");

  a_emit_resets: assert property (@(posedge clk) disable iff (!rst_n)
    consume && ctl.emit |=> (phase_r == ilex_pkg::PH_START && out_v_r))
    else $error("result did not reset lexer or load output");

  a_out_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_v_r) |-> $past(consume && ctl.emit))
    else $error("result valid without an emitting character");

  a_stall_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (s1_v_r && out_v_r && out_stall))
    else $error("input stalled without a blocked result");

endmodule

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Streams text into integer_literal_lexer one character per beat. It checks
// every result beat against a lexer model kept in the testbench, runs with
// and without random idling on either side, holds off the result side for
// a long stretch, and drives one hex literal long enough to wrap the value.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  typedef logic [ilex_pkg::CHAR_W-1:0] char_t;

  typedef struct {
    char_t ch;
    logic  eot;
  } char_beat_t;

  typedef struct {
    logic [ilex_pkg::VALUE_W-1:0] value;
    logic [ilex_pkg::LEN_W-1:0]   len;
    logic                         part;
  } literal_t;

  logic                         clk = 1'b0;
  logic                         rst_n = 1'b0;
  logic                         in_valid = 1'b0;
  logic                         in_stall;
  char_t                        in_text_char = '0;
  logic                         in_end_of_text = 1'b0;
  logic                         out_valid;
  logic                         out_stall = 1'b0;
  logic [ilex_pkg::VALUE_W-1:0] out_literal_value;
  logic [ilex_pkg::LEN_W-1:0]   out_consumed_length;
  logic                         out_char_was_part;

  char_beat_t text_q[$];
  literal_t   literal_q[$];

  int  send_idle_pct = 0;
  int  recv_stall_pct = 0;
  logic hold_out = 1'b0;
  bit  press_go = 1'b0;
  int  fail_cnt = 0;

  // lexer model state
  ilex_pkg::phase_t             lx_phase = ilex_pkg::PH_START;
  logic [ilex_pkg::VALUE_W-1:0] lx_acc = '0;
  logic                         lx_neg = 1'b0;
  logic [ilex_pkg::LEN_W-1:0]   lx_count = '0;

  integer_literal_lexer dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_text_char        (in_text_char),
    .in_end_of_text      (in_end_of_text),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_literal_value   (out_literal_value),
    .out_consumed_length (out_consumed_length),
    .out_char_was_part   (out_char_was_part)
  );

  always #5 clk = ~clk;

  function automatic int digit_of(char_t c, int base);
    char_t low;
    low = c | ilex_pkg::CASE_BIT;
    if (c >= ilex_pkg::CH_ZERO && c <= ilex_pkg::CH_NINE && (c - ilex_pkg::CH_ZERO) < base)
      return c - ilex_pkg::CH_ZERO;
    if (base == 16 && low >= ilex_pkg::CH_LC_A && low <= ilex_pkg::CH_LC_F)
      return low - ilex_pkg::CH_LC_A + 10;
    return -1;
  endfunction

  function automatic void close_literal(logic part);
    literal_t r;
    r.value = lx_neg ? (64'd0 - lx_acc) : lx_acc;
    r.len = lx_count;
    r.part = part;
    literal_q.push_back(r);
    lx_phase = ilex_pkg::PH_START;
    lx_acc = '0;
    lx_neg = 1'b0;
    lx_count = '0;
  endfunction

  function automatic void lex_char(char_t c, logic eot);
    logic part;
    logic handled;
    int   base;
    int   d;
    part = 1'b0;
    handled = 1'b0;
    if (lx_phase == ilex_pkg::PH_START && c == ilex_pkg::CH_MINUS) begin
      lx_neg = 1'b1;
      lx_phase = ilex_pkg::PH_SIGNED;
      part = 1'b1;
      handled = 1'b1;
    end else if ((lx_phase == ilex_pkg::PH_START || lx_phase == ilex_pkg::PH_SIGNED) &&
                 c == ilex_pkg::CH_ZERO) begin
      lx_phase = ilex_pkg::PH_ZERO;
      part = 1'b1;
      handled = 1'b1;
    end else if (lx_phase == ilex_pkg::PH_ZERO && !eot &&
                 (c == ilex_pkg::CH_LC_X || c == ilex_pkg::CH_LC_B ||
                  c == ilex_pkg::CH_LC_O)) begin
      lx_phase = (c == ilex_pkg::CH_LC_X) ? ilex_pkg::PH_HEX :
                 (c == ilex_pkg::CH_LC_B) ? ilex_pkg::PH_BIN : ilex_pkg::PH_OCT;
      part = 1'b1;
      handled = 1'b1;
    end
    if (!handled) begin
      if (lx_phase != ilex_pkg::PH_HEX && lx_phase != ilex_pkg::PH_BIN &&
          lx_phase != ilex_pkg::PH_OCT) lx_phase = ilex_pkg::PH_DEC;
      case (lx_phase)
        ilex_pkg::PH_HEX: base = 16;
        ilex_pkg::PH_BIN: base = 2;
        ilex_pkg::PH_OCT: base = 8;
        default:          base = 10;
      endcase
      if (c == ilex_pkg::CH_UNDER) begin
        part = 1'b1;
      end else begin
        d = digit_of(c, base);
        if (d >= 0) begin
          lx_acc = lx_acc * 64'(base) + 64'(d);
          part = 1'b1;
        end
      end
    end
    if (!part) begin
      close_literal(1'b0);
    end else begin
      if (lx_count != {ilex_pkg::LEN_W{1'b1}}) lx_count = lx_count + 1'b1;
      if (eot) close_literal(1'b1);
    end
  endfunction

  // driver
  always @(posedge clk) begin
    char_beat_t nxt;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) lex_char(in_text_char, in_end_of_text);
      if (!in_valid || !in_stall) begin
        if (text_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          nxt = text_q.pop_front();
          in_valid <= 1'b1;
          in_text_char <= nxt.ch;
          in_end_of_text <= nxt.eot;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    literal_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (literal_q.size() == 0) begin
          fail_cnt++;
          if (fail_cnt <= 10)
            $display("unexpected beat: value %h len %0d part %b", out_literal_value,
                     out_consumed_length, out_char_was_part);
        end else begin
          want = literal_q.pop_front();
          if (out_literal_value !== want.value || out_consumed_length !== want.len ||
              out_char_was_part !== want.part) begin
            fail_cnt++;
            if (fail_cnt <= 10)
              $display("mismatch: exp value %h len %0d part %b, got value %h len %0d part %b",
                       want.value, want.len, want.part, out_literal_value,
                       out_consumed_length, out_char_was_part);
          end
        end
      end
      out_stall <= hold_out || ($urandom_range(99) < recv_stall_pct);
    end
  end

  // long hold-off on the result side while the sender keeps offering
  initial begin
    wait (press_go);
    repeat (20) @(posedge clk);
    hold_out <= 1'b1;
    repeat (300) @(posedge clk);
    hold_out <= 1'b0;
  end

  initial begin
    #5ms;
    $display("tb: failure");
    $finish;
  end

  task automatic put(char_t c, logic eot);
    char_beat_t b;
    b.ch = c;
    b.eot = eot;
    text_q.push_back(b);
  endtask

  function automatic char_t digit_char(int base);
    int d;
    d = $urandom_range(base - 1);
    if (d < 10) return char_t'(ilex_pkg::CH_ZERO + d);
    if ($urandom_range(1)) return char_t'(ilex_pkg::CH_LC_A + d - 10);
    return char_t'((ilex_pkg::CH_LC_A ^ ilex_pkg::CASE_BIT) + d - 10);
  endfunction

  function automatic char_t prefix_letter();
    case ($urandom_range(2))
      0:       return ilex_pkg::CH_LC_X;
      1:       return ilex_pkg::CH_LC_B;
      default: return ilex_pkg::CH_LC_O;
    endcase
  endfunction

  task automatic add_literal();
    char_t body[$];
    int    base;
    int    ndig;
    int    k;
    base = 10;
    if ($urandom_range(3) == 0) body.push_back(ilex_pkg::CH_MINUS);
    case ($urandom_range(3))
      1: begin
        body.push_back(ilex_pkg::CH_ZERO); body.push_back(ilex_pkg::CH_LC_X); base = 16;
      end
      2: begin
        body.push_back(ilex_pkg::CH_ZERO); body.push_back(ilex_pkg::CH_LC_B); base = 2;
      end
      3: begin
        body.push_back(ilex_pkg::CH_ZERO); body.push_back(ilex_pkg::CH_LC_O); base = 8;
      end
      default: ;
    endcase
    ndig = ($urandom_range(9) == 0) ? $urandom_range(24) : $urandom_range(1, 20);
    for (k = 0; k < ndig; k++)
      body.push_back(($urandom_range(7) == 0) ? ilex_pkg::CH_UNDER : digit_char(base));
    if (body.size() != 0 && $urandom_range(1)) begin
      for (k = 0; k < body.size(); k++) put(body[k], k == body.size() - 1);
    end else begin
      foreach (body[i]) put(body[i], 1'b0);
      put(char_t'($urandom_range(255)), $urandom_range(3) == 0);
    end
  endtask

  task automatic add_broken();
    case ($urandom_range(3))
      0: begin put(ilex_pkg::CH_ZERO, 1'b0); put(prefix_letter(), 1'b1); end
      1: begin
        if ($urandom_range(1)) put(ilex_pkg::CH_MINUS, 1'b0);
        put(ilex_pkg::CH_ZERO, 1'b0);
        put(prefix_letter(), 1'b0);
        put(char_t'($urandom_range(255)), $urandom_range(1));
      end
      2: begin
        put(ilex_pkg::CH_MINUS, 1'b0);
        put(char_t'($urandom_range(255)), $urandom_range(1));
      end
      default: begin
        put(ilex_pkg::CH_UNDER, 1'b0);
        put(ilex_pkg::CH_ZERO, 1'b0);
        put(prefix_letter(), 1'b0);
        put(digit_char(16), 1'b1);
      end
    endcase
  endtask

  task automatic add_random(int n);
    int pick;
    while (text_q.size() < n) begin
      pick = $urandom_range(99);
      if (pick < 70) add_literal();
      else if (pick < 85) add_broken();
      else put(char_t'($urandom_range(255)), $urandom_range(3) == 0);
    end
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (text_q.size() != 0 || in_valid || literal_q.size() != 0);
  endtask

  initial begin
    int k;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // no digits at all
    put("z", 1'b0);
    put(8'hff, 1'b0);
    put(8'h80, 1'b0);
    // lone minus
    put(ilex_pkg::CH_MINUS, 1'b0); put(",", 1'b0);
    // prefix letter as final character
    put(ilex_pkg::CH_ZERO, 1'b0); put(ilex_pkg::CH_LC_X, 1'b1);
    // prefix with empty body
    put(ilex_pkg::CH_ZERO, 1'b0); put(ilex_pkg::CH_LC_B, 1'b0); put("2", 1'b0);
    // underscore before a would-be prefix
    put(ilex_pkg::CH_UNDER, 1'b0); put(ilex_pkg::CH_ZERO, 1'b0);
    put(ilex_pkg::CH_LC_X, 1'b0); put(ilex_pkg::CH_ONE, 1'b1);
    // signed octal, minus one, mixed-case hex
    put(ilex_pkg::CH_MINUS, 1'b0); put(ilex_pkg::CH_ZERO, 1'b0);
    put(ilex_pkg::CH_LC_O, 1'b0); put(ilex_pkg::CH_ONE, 1'b0);
    put(ilex_pkg::CH_SEVEN, 1'b1);
    put(ilex_pkg::CH_MINUS, 1'b0); put(ilex_pkg::CH_ONE, 1'b1);
    put(ilex_pkg::CH_ZERO, 1'b0); put(ilex_pkg::CH_LC_X, 1'b0);
    put(8'h61, 1'b0); put(8'h46, 1'b1);
    put(ilex_pkg::CH_ZERO, 1'b1);

    // long hex literal, value wraps
    put(ilex_pkg::CH_ZERO, 1'b0);
    put(ilex_pkg::CH_LC_X, 1'b0);
    for (k = 0; k < 30; k++)
      put(($urandom_range(3) == 0) ? ilex_pkg::CH_UNDER : digit_char(16), k == 29);
    wait_drained();

    press_go = 1'b1;
    add_random(90);
    wait_drained();

    send_idle_pct = 88;
    recv_stall_pct = 0;
    add_random(90);
    wait_drained();

    send_idle_pct = 0;
    recv_stall_pct = 88;
    add_random(90);
    wait_drained();

    send_idle_pct = 33;
    recv_stall_pct = 33;
    add_random(90);
    put(ilex_pkg::CH_ZERO, 1'b1);
    wait_drained();

    repeat (8) @(negedge clk);
    if (fail_cnt == 0 && literal_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/ilex_pkg.sv
rtl/ilex_step.sv
rtl/integer_literal_lexer.sv
tb/testbench.sv
